// ===== rtl/wwt_pkg.sv =====
`timescale 1ns / 1ps

package wwt_pkg;

    localparam int DEF_COUNT_WIDTH  = 24;
    localparam int DEF_SAMPLE_WIDTH = 16;

    localparam int          WORD_W      = 64;
    localparam int          DIV_STEPS   = 64;
    localparam int          DIV_CNT_W   = $clog2(DIV_STEPS + 1);
    localparam logic [15:0] THR_RESET   = 16'd1152;
    localparam logic [31:0] T_MAG_MAX   = 32'h7FFF_FFFF;

    // divider status back to the sequencer
    typedef struct packed {
        logic done;
        logic clip;
    } div_stat_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PREP,
        ST_MGO,
        ST_MWAIT,
        ST_DIFF2,
        ST_PROD,
        ST_ACC,
        ST_CHK,
        ST_VGO,
        ST_VWAIT,
        ST_NGO,
        ST_NWAIT,
        ST_DIFFM,
        ST_SQR,
        ST_QGO,
        ST_QWAIT,
        ST_SGO,
        ST_SWAIT,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/wwt_div.sv =====
`timescale 1ns / 1ps

// Restoring divider, floor((hi:lo) / divisor), one quotient bit per cycle.
// Clips to all ones when hi >= divisor.
module wwt_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [wwt_pkg::WORD_W-1:0]    hi,
    input  logic [wwt_pkg::WORD_W-1:0]    lo,
    input  logic [wwt_pkg::WORD_W-1:0]    divisor,
    output logic [wwt_pkg::WORD_W-1:0]    quot,
    output wwt_pkg::div_stat_t            stat
);

    logic                              busy_reg;
    logic [wwt_pkg::DIV_CNT_W-1:0]     cnt_reg;
    logic                              done_reg;
    logic                              clip_reg;
    logic [wwt_pkg::WORD_W-1:0]        rem_reg;
    logic [wwt_pkg::WORD_W-1:0]        lo_reg;
    logic [wwt_pkg::WORD_W-1:0]        v_reg;
    logic [wwt_pkg::WORD_W-1:0]        quot_reg;

    logic [wwt_pkg::WORD_W-1:0]        rem_sh;
    logic                              take;
    logic [wwt_pkg::WORD_W-1:0]        rem_nx;
    logic                              over;

    assign over   = (hi >= divisor);
    assign rem_sh = {rem_reg[wwt_pkg::WORD_W-2:0], lo_reg[wwt_pkg::WORD_W-1]};
    assign take   = rem_reg[wwt_pkg::WORD_W-1] | (rem_sh >= v_reg);
    assign rem_nx = take ? (rem_sh - v_reg) : rem_sh;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
            clip_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                clip_reg <= over;
                busy_reg <= ~over;
                done_reg <= over;
                cnt_reg  <= wwt_pkg::DIV_CNT_W'(wwt_pkg::DIV_STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - wwt_pkg::DIV_CNT_W'(1);
                if (cnt_reg == wwt_pkg::DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= hi;
            lo_reg   <= lo;
            v_reg    <= divisor;
            quot_reg <= over ? '1 : '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_nx;
            lo_reg   <= {lo_reg[wwt_pkg::WORD_W-2:0], 1'b0};
            quot_reg <= {quot_reg[wwt_pkg::WORD_W-2:0], take};
        end
    end

    assign quot      = quot_reg;
    assign stat.done = done_reg;
    assign stat.clip = clip_reg;

endmodule

// ===== rtl/wwt_sqrt.sv =====
`timescale 1ns / 1ps

// Integer square root, two radicand bits per cycle.
module wwt_sqrt
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [wwt_pkg::WORD_W-1:0]    radicand,
    output logic [31:0]                   root,
    output logic                          done
);

    logic                              busy_reg;
    logic                              done_reg;
    logic [wwt_pkg::WORD_W-1:0]        x_reg;
    logic [wwt_pkg::WORD_W-1:0]        res_reg;
    logic [wwt_pkg::WORD_W-1:0]        bit_reg;

    logic [wwt_pkg::WORD_W-1:0]        trial;
    logic                              fits;

    assign trial = res_reg + bit_reg;
    assign fits  = (x_reg >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && bit_reg[0])
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= radicand;
            res_reg <= '0;
            bit_reg <= wwt_pkg::WORD_W'(1) << (wwt_pkg::WORD_W - 2);
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                x_reg   <= x_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign root = res_reg[31:0];
    assign done = done_reg;

endmodule

// ===== rtl/welford_welch_ttest_accumulator_unit.sv =====
`timescale 1ns / 1ps
// Work per item: one 64-step division while either class holds fewer than two samples,
//   six 64-step divisions plus a 32-step square root once both do, five on zero variance.
// Items are handled one at a time through the shared divider. The next item is
//   taken as soon as the result is in the output register.
// Reset (rst_n, async, active low): counts, means and deviation sums clear, threshold
//   returns to 4.5 (Q8.8), output register empties.
module welford_welch_ttest_accumulator_unit
#(
    parameter int COUNT_WIDTH  = wwt_pkg::DEF_COUNT_WIDTH,
    parameter int SAMPLE_WIDTH = wwt_pkg::DEF_SAMPLE_WIDTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    // sample items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] measured_time
    input  logic        s_tuser,   // [0] sample_class
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] t_value, [32] enough_data, [33] passed,
                                   // [34] saturated, [39:35] zero
    // threshold register
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    localparam int CW      = COUNT_WIDTH;
    localparam int SW_EFF  = (SAMPLE_WIDTH < 16) ? SAMPLE_WIDTH : 16;
    localparam logic [15:0] SMASK = 16'((32'd1 << SW_EFF) - 32'd1);
    localparam logic [CW-1:0] CMAX = '1;

    // per-class statistics
    logic [CW-1:0] count_reg [2];
    logic [CW-1:0] count_next [2];
    logic [31:0]   mean_reg [2];
    logic [31:0]   mean_next [2];
    logic [63:0]   dev_reg [2];
    logic [63:0]   dev_next [2];

    wwt_pkg::state_t state_reg, state_next;

    logic        cls_reg, cls_next;
    logic [31:0] x_reg, x_next;
    logic        dneg_reg, dneg_next;
    logic [31:0] dmag_reg, dmag_next;
    logic [31:0] mag2_reg, mag2_next;
    logic        sel_reg, sel_next;
    logic        clip_reg, clip_next;
    logic        enough_reg, enough_next;
    logic [63:0] prod_reg, prod_next;
    logic [63:0] term_reg, term_next;
    logic [63:0] den_reg, den_next;
    logic [63:0] quo_reg, quo_next;
    logic        tneg_reg, tneg_next;
    logic [31:0] mag_reg, mag_next;
    logic [15:0] thr_reg;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [39:0] m_tdata_reg, m_tdata_next;

    // shared subtractor
    logic [31:0] sub_a, sub_b;
    logic [32:0] sub_res;
    logic [32:0] sub_negated;
    logic [31:0] sub_mag;

    // divider and root unit
    logic                div_start;
    logic [63:0]         div_hi, div_lo, div_v;
    logic [63:0]         div_q;
    wwt_pkg::div_stat_t  div_st;
    logic                sq_start;
    logic [31:0]         sq_root;
    logic                sq_done;

    logic [63:0] product;
    logic [39:0] prod_shr;
    logic [64:0] acc_sum;
    logic [64:0] den_sum;
    logic [63:0] den_sat;
    logic [CW-1:0] count_sel;
    logic [CW-1:0] count_cur;
    logic [31:0] tv;
    logic        pass_flag;

    assign sub_res     = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_negated = ~sub_res + 33'd1;
    assign sub_mag     = sub_res[32] ? sub_negated[31:0] : sub_res[31:0];

    // one multiplier, operands registered
    assign product  = dmag_reg * mag2_reg;
    assign prod_shr = prod_reg[63:24];
    assign acc_sum  = {1'b0, dev_reg[cls_reg]} + {25'd0, prod_shr};
    assign den_sum  = {1'b0, term_reg} + {1'b0, div_q};
    assign den_sat  = den_sum[64] ? '1 : den_sum[63:0];

    assign count_sel = count_reg[sel_reg];
    assign count_cur = count_reg[s_tuser];

    assign tv        = tneg_reg ? (~mag_reg + 32'd1) : mag_reg;
    assign pass_flag = enough_reg && (mag_reg < {8'd0, thr_reg, 8'd0});

    assign s_tready  = (state_reg == wwt_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign div_start = (state_reg == wwt_pkg::ST_MGO) || (state_reg == wwt_pkg::ST_VGO) ||
                       (state_reg == wwt_pkg::ST_NGO) || (state_reg == wwt_pkg::ST_QGO);
    assign sq_start  = (state_reg == wwt_pkg::ST_SGO);

    wwt_div u_div
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .hi      (div_hi),
        .lo      (div_lo),
        .divisor (div_v),
        .quot    (div_q),
        .stat    (div_st)
    );

    wwt_sqrt u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (quo_reg),
        .root     (sq_root),
        .done     (sq_done)
    );

    // divider operands by step
    always_comb
    begin
        div_hi = '0;
        div_lo = '0;
        div_v  = 64'd1;
        case (state_reg)
            wwt_pkg::ST_MGO:
            begin
                // |delta| / n for the mean update
                div_lo = {32'd0, dmag_reg};
                div_v  = 64'(count_reg[cls_reg]);
            end
            wwt_pkg::ST_VGO:
            begin
                // dev * 2^24 / (n - 1)
                div_hi = {40'd0, dev_reg[sel_reg][63:40]};
                div_lo = {dev_reg[sel_reg][39:0], 24'd0};
                div_v  = 64'(count_sel - CW'(1));
            end
            wwt_pkg::ST_NGO:
            begin
                div_lo = quo_reg;
                div_v  = 64'(count_sel);
            end
            wwt_pkg::ST_QGO:
            begin
                // d^2 * 2^32 / D
                div_hi = {32'd0, prod_reg[63:32]};
                div_lo = {prod_reg[31:0], 32'd0};
                div_v  = den_reg;
            end
            default:
            begin
                div_v = 64'd1;
            end
        endcase
    end

    // subtractor operands
    always_comb
    begin
        sub_a = x_reg;
        sub_b = mean_reg[cls_reg];
        if (state_reg == wwt_pkg::ST_DIFFM)
        begin
            sub_a = mean_reg[0];
            sub_b = mean_reg[1];
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cls_next      = cls_reg;
        x_next        = x_reg;
        dneg_next     = dneg_reg;
        dmag_next     = dmag_reg;
        mag2_next     = mag2_reg;
        sel_next      = sel_reg;
        clip_next     = clip_reg;
        enough_next   = enough_reg;
        prod_next     = prod_reg;
        term_next     = term_reg;
        den_next      = den_reg;
        quo_next      = quo_reg;
        tneg_next     = tneg_reg;
        mag_next      = mag_reg;
        count_next    = count_reg;
        mean_next     = mean_reg;
        dev_next      = dev_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;

        unique case (state_reg)
            wwt_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cls_next = s_tuser;
                    x_next   = {s_tdata & SMASK, 16'd0};
                    // count holds at full scale and flags it
                    if (count_cur == CMAX)
                    begin
                        clip_next = 1'b1;
                    end
                    else
                    begin
                        clip_next = 1'b0;
                        count_next[s_tuser] = count_cur + CW'(1);
                    end
                    state_next = wwt_pkg::ST_PREP;
                end
            end
            wwt_pkg::ST_PREP:
            begin
                dneg_next  = sub_res[32];
                dmag_next  = sub_mag;
                state_next = wwt_pkg::ST_MGO;
            end
            wwt_pkg::ST_MGO:
            begin
                state_next = wwt_pkg::ST_MWAIT;
            end
            wwt_pkg::ST_MWAIT:
            begin
                if (div_st.done)
                begin
                    // truncation toward zero: apply the sign to the magnitude quotient
                    mean_next[cls_reg] = dneg_reg ? (mean_reg[cls_reg] - div_q[31:0])
                                                  : (mean_reg[cls_reg] + div_q[31:0]);
                    state_next = wwt_pkg::ST_DIFF2;
                end
            end
            wwt_pkg::ST_DIFF2:
            begin
                mag2_next  = sub_mag;
                state_next = wwt_pkg::ST_PROD;
            end
            wwt_pkg::ST_PROD:
            begin
                prod_next  = product;
                state_next = wwt_pkg::ST_ACC;
            end
            wwt_pkg::ST_ACC:
            begin
                if (acc_sum[64])
                begin
                    dev_next[cls_reg] = '1;
                    clip_next         = 1'b1;
                end
                else
                begin
                    dev_next[cls_reg] = acc_sum[63:0];
                end
                state_next = wwt_pkg::ST_CHK;
            end
            wwt_pkg::ST_CHK:
            begin
                enough_next = (count_reg[0] >= CW'(2)) && (count_reg[1] >= CW'(2));
                sel_next    = 1'b0;
                mag_next    = '0;
                tneg_next   = 1'b0;
                if (enough_next)
                begin
                    state_next = wwt_pkg::ST_VGO;
                end
                else
                begin
                    state_next = wwt_pkg::ST_DONE;
                end
            end
            wwt_pkg::ST_VGO:
            begin
                state_next = wwt_pkg::ST_VWAIT;
            end
            wwt_pkg::ST_VWAIT:
            begin
                if (div_st.done)
                begin
                    clip_next  = clip_reg | div_st.clip;
                    quo_next   = div_q;
                    state_next = wwt_pkg::ST_NGO;
                end
            end
            wwt_pkg::ST_NGO:
            begin
                state_next = wwt_pkg::ST_NWAIT;
            end
            wwt_pkg::ST_NWAIT:
            begin
                if (div_st.done)
                begin
                    if (!sel_reg)
                    begin
                        term_next  = div_q;
                        sel_next   = 1'b1;
                        state_next = wwt_pkg::ST_VGO;
                    end
                    else
                    begin
                        clip_next = clip_reg | den_sum[64];
                        den_next  = den_sat;
                        // zero variance leaves t at zero
                        if (den_sat == '0)
                        begin
                            state_next = wwt_pkg::ST_DONE;
                        end
                        else
                        begin
                            state_next = wwt_pkg::ST_DIFFM;
                        end
                    end
                end
            end
            wwt_pkg::ST_DIFFM:
            begin
                tneg_next  = sub_res[32];
                dmag_next  = sub_mag;
                mag2_next  = sub_mag;
                state_next = wwt_pkg::ST_SQR;
            end
            wwt_pkg::ST_SQR:
            begin
                prod_next  = product;
                state_next = wwt_pkg::ST_QGO;
            end
            wwt_pkg::ST_QGO:
            begin
                state_next = wwt_pkg::ST_QWAIT;
            end
            wwt_pkg::ST_QWAIT:
            begin
                if (div_st.done)
                begin
                    clip_next  = clip_reg | div_st.clip;
                    quo_next   = div_q;
                    state_next = wwt_pkg::ST_SGO;
                end
            end
            wwt_pkg::ST_SGO:
            begin
                state_next = wwt_pkg::ST_SWAIT;
            end
            wwt_pkg::ST_SWAIT:
            begin
                if (sq_done)
                begin
                    if (sq_root[31])
                    begin
                        mag_next  = wwt_pkg::T_MAG_MAX;
                        clip_next = 1'b1;
                    end
                    else
                    begin
                        mag_next = sq_root;
                    end
                    state_next = wwt_pkg::ST_DONE;
                end
            end
            wwt_pkg::ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {5'd0, clip_reg, pass_flag, enough_reg, tv};
                    state_next    = wwt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wwt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= wwt_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
            thr_reg      <= wwt_pkg::THR_RESET;
            count_reg[0] <= '0;
            count_reg[1] <= '0;
            mean_reg[0]  <= '0;
            mean_reg[1]  <= '0;
            dev_reg[0]   <= '0;
            dev_reg[1]   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            count_reg    <= count_next;
            mean_reg     <= mean_next;
            dev_reg      <= dev_next;
            if (cfg_valid && cfg_ready)
            begin
                thr_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cls_reg     <= cls_next;
        x_reg       <= x_next;
        dneg_reg    <= dneg_next;
        dmag_reg    <= dmag_next;
        mag2_reg    <= mag2_next;
        sel_reg     <= sel_next;
        clip_reg    <= clip_next;
        enough_reg  <= enough_next;
        prod_reg    <= prod_next;
        term_reg    <= term_next;
        den_reg     <= den_next;
        quo_reg     <= quo_next;
        tneg_reg    <= tneg_next;
        mag_reg     <= mag_next;
        m_tdata_reg <= m_tdata_next;
    end

    // an accepted sample always starts the update sequence
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == wwt_pkg::ST_PREP))
        else $error("accepted sample did not start update");

    // a pass result always carries enough data
    a_pass_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (!m_tdata[33] || m_tdata[32]))
        else $error("passed without enough data");

    // counts never move backward
    a_count0_mono: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg[0] >= $past(count_reg[0]))
        else $error("class 0 count decreased");

    a_count1_mono: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg[1] >= $past(count_reg[1]))
        else $error("class 1 count decreased");

endmodule
